/* rtl/core/hcbd_pkg.sv */
// Shared types, constants and helpers of the home computer bus decoder.
package hcbd_pkg;

    localparam int RAM_DEPTH  = 32768;
    localparam int ROM_DEPTH  = 8192;
    localparam int RAM_AW     = $clog2(RAM_DEPTH);
    localparam int ROM_AW     = $clog2(ROM_DEPTH);
    localparam int SIZE_W     = RAM_AW + 1;
    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int FETCH_W    = 11;
    localparam int ROWS_W     = 6;
    localparam int KIB_W      = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam int KIB_RESET  = 4;
    localparam int SIZE_RESET = (KIB_RESET * 1024 > RAM_DEPTH) ? RAM_DEPTH : KIB_RESET * 1024;
    localparam int QUAD_SPAN  = 16'h4000;

    localparam logic [BYTE_W-1:0] ROW_PAD     = 8'hc0;
    localparam logic [BYTE_W-1:0] FETCH_BLANK = 8'hff;

    typedef enum logic [1:0] {
        ACT_READ     = 2'd0,
        ACT_WRITE    = 2'd1,
        ACT_FETCH    = 2'd2,
        ACT_ROM_LOAD = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        QUAD_FLOAT = 2'd0,
        QUAD_RAM   = 2'd1,
        QUAD_IO    = 2'd2,
        QUAD_ROM   = 2'd3
    } quad_t;

    typedef enum logic [1:0] {
        BSRC_FIXED,
        BSRC_RAM,
        BSRC_ROM
    } byte_src_t;

    // Video mode latch bit shuffle.
    function automatic logic [BYTE_W-1:0] remap_mode(input logic [BYTE_W-1:0] d);
        logic [BYTE_W-1:0] v;
        v = '0;
        v[7] = d[5];
        v[6] = d[2];
        v[5] = d[3];
        v[4] = d[4];
        v[3] = d[6];
        return v;
    endfunction

endpackage

/* rtl/core/hcbd_if.sv */
// Valid/ready channel interfaces for bus transactions and results.
interface hcbd_bus_if;
    logic                            valid;
    logic                            ready;
    hcbd_pkg::action_t               action;
    logic [hcbd_pkg::ADDR_W-1:0]     address;
    logic [hcbd_pkg::BYTE_W-1:0]     data;
    logic [hcbd_pkg::ROWS_W-1:0]     keyboard_rows;

    modport source (output valid, action, address, data, keyboard_rows, input ready);
    modport sink   (input valid, action, address, data, keyboard_rows, output ready);
endinterface

interface hcbd_result_if;
    logic                            valid;
    logic                            ready;
    logic [hcbd_pkg::BYTE_W-1:0]     read_data;
    logic [hcbd_pkg::FETCH_W-1:0]    fetch_word;
    logic [hcbd_pkg::BYTE_W-1:0]     screen_mode;
    logic                            sound_bit;

    modport source (output valid, read_data, fetch_word, screen_mode, sound_bit, input ready);
    modport sink   (input valid, read_data, fetch_word, screen_mode, sound_bit, output ready);
endinterface

/* rtl/core/home_computer_bus_decoder_unit.sv */
// Top level of the home computer bus decoder: address decode, RAM, ROM, latches.
// Pipeline: a transaction passes the input register, the RAM/ROM registered read and the
//   result queue before its result shows valid.
// Throughput: one transaction per cycle, set by the single RAM port, while the result queue has room.
// Reset: latches clear, the installed size returns to 4 KiB, and a clearing pass zeroes all
//   RAM_DEPTH (32768) RAM bytes one byte per cycle with bus.ready low. ROM keeps its contents.
module home_computer_bus_decoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    hcbd_bus_if.sink                      bus,
    hcbd_result_if.source                 result,
    input  logic                          cfg_we,
    input  logic [hcbd_pkg::KIB_W-1:0]    cfg_wdata
);

    // Stage 2 carries everything the result needs besides the memory read data.
    typedef struct packed {
        logic                           is_read;
        logic                           is_fetch;
        hcbd_pkg::byte_src_t            src;
        logic [hcbd_pkg::BYTE_W-1:0]    fixed;
        logic                           attr;
        logic [hcbd_pkg::BYTE_W-1:0]    mode;
        logic                           sound;
    } stage2_t;

    typedef struct packed {
        logic [hcbd_pkg::BYTE_W-1:0]    read_data;
        logic [hcbd_pkg::FETCH_W-1:0]   fetch_word;
        logic [hcbd_pkg::BYTE_W-1:0]    screen_mode;
        logic                           sound_bit;
    } result_t;

    // ---------------- configuration: installed size in bytes, saturated ----------------
    logic [hcbd_pkg::SIZE_W-1:0] size_reg;
    logic [hcbd_pkg::SIZE_W-1:0] size_next;
    logic [hcbd_pkg::ADDR_W-1:0] kib_bytes;

    assign kib_bytes = {cfg_wdata, 10'b0};

    always_comb
    begin
        if (kib_bytes > hcbd_pkg::ADDR_W'(hcbd_pkg::RAM_DEPTH))
        begin
            size_next = hcbd_pkg::SIZE_W'(hcbd_pkg::RAM_DEPTH);
        end
        else
        begin
            size_next = kib_bytes[hcbd_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= hcbd_pkg::SIZE_W'(hcbd_pkg::SIZE_RESET);
        end
        else if (cfg_we)
        begin
            size_reg <= size_next;
        end
    end

    // ---------------- RAM clearing pass after reset ----------------
    logic                        clear_reg;
    logic [hcbd_pkg::RAM_AW-1:0] clear_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == hcbd_pkg::RAM_AW'(hcbd_pkg::RAM_DEPTH - 1))
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    // ---------------- result queue bookkeeping and input acceptance ----------------
    // Admit a transaction only if every one in flight is sure of a queue slot.
    logic                         s1_v_reg;
    logic                         s2_v_reg;
    logic [hcbd_pkg::FIFO_CW-1:0] count_reg;
    logic [hcbd_pkg::FIFO_CW-1:0] pending;
    logic                         accept;

    assign pending   = count_reg + hcbd_pkg::FIFO_CW'(s1_v_reg) + hcbd_pkg::FIFO_CW'(s2_v_reg);
    assign bus.ready = !clear_reg && (pending < hcbd_pkg::FIFO_CW'(hcbd_pkg::FIFO_DEPTH));
    assign accept    = bus.valid && bus.ready;

    // ---------------- stage 1: input register ----------------
    hcbd_pkg::action_t             s1_action_reg;
    logic [hcbd_pkg::ADDR_W-1:0]   s1_addr_reg;
    logic [hcbd_pkg::BYTE_W-1:0]   s1_data_reg;
    logic [hcbd_pkg::ROWS_W-1:0]   s1_rows_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= bus.action;
            s1_addr_reg   <= bus.address;
            s1_data_reg   <= bus.data;
            s1_rows_reg   <= bus.keyboard_rows;
        end
    end

    // ---------------- stage 1 decode ----------------
    hcbd_pkg::quad_t               quad;
    logic [14:0]                   off;
    logic [hcbd_pkg::ADDR_W-1:0]   size_wide;
    logic                          off_hit;
    logic                          fetch_hit;
    logic                          ram_mapped;

    logic                          ram_we;
    logic [hcbd_pkg::RAM_AW-1:0]   ram_addr;
    logic [hcbd_pkg::BYTE_W-1:0]   ram_wdata;
    logic [hcbd_pkg::BYTE_W-1:0]   ram_rdata;
    logic                          rom_we;
    logic [hcbd_pkg::BYTE_W-1:0]   rom_rdata;
    logic                          latch_we;

    logic [hcbd_pkg::BYTE_W-1:0]   mode_reg;
    logic                          attr_reg;
    logic                          sound_reg;
    logic [hcbd_pkg::BYTE_W-1:0]   mode_next;
    logic                          attr_next;
    logic                          sound_next;

    stage2_t                       s2_next;
    stage2_t                       s2_reg;

    assign quad      = hcbd_pkg::quad_t'(s1_addr_reg[15:14]);
    // address - 0x4000 for quadrants 1 and 2
    assign off       = {s1_addr_reg[15], s1_addr_reg[13:0]};
    assign size_wide = hcbd_pkg::ADDR_W'(size_reg);
    assign off_hit   = {1'b0, off} < size_wide;
    assign fetch_hit = s1_addr_reg < size_wide;

    always_comb
    begin
        unique case (quad)
            hcbd_pkg::QUAD_RAM: ram_mapped = off_hit;
            hcbd_pkg::QUAD_IO:  ram_mapped = off_hit &&
                                    (size_wide > hcbd_pkg::ADDR_W'(hcbd_pkg::QUAD_SPAN));
            default:            ram_mapped = 1'b0;
        endcase
    end

    always_comb
    begin
        ram_we           = 1'b0;
        rom_we           = 1'b0;
        latch_we         = 1'b0;
        s2_next.is_read  = 1'b0;
        s2_next.is_fetch = 1'b0;
        s2_next.src      = hcbd_pkg::BSRC_FIXED;
        s2_next.fixed    = s1_data_reg;
        ram_addr         = off;
        // Fetch sees the attribute as it stands for this transaction.
        s2_next.attr     = attr_reg;
        s2_next.mode     = mode_next;
        s2_next.sound    = sound_next;

        unique case (s1_action_reg)
            hcbd_pkg::ACT_READ:
            begin
                s2_next.is_read = 1'b1;
                if (quad == hcbd_pkg::QUAD_ROM)
                begin
                    s2_next.src = hcbd_pkg::BSRC_ROM;
                end
                else if (ram_mapped)
                begin
                    s2_next.src = hcbd_pkg::BSRC_RAM;
                end
                else if (quad == hcbd_pkg::QUAD_IO)
                begin
                    s2_next.fixed = {2'b00, s1_rows_reg} | hcbd_pkg::ROW_PAD;
                end
            end
            hcbd_pkg::ACT_WRITE:
            begin
                if (ram_mapped)
                begin
                    ram_we = s1_v_reg;
                end
                else if (quad == hcbd_pkg::QUAD_IO)
                begin
                    latch_we = s1_v_reg;
                end
            end
            hcbd_pkg::ACT_FETCH:
            begin
                s2_next.is_fetch = 1'b1;
                ram_addr         = s1_addr_reg[hcbd_pkg::RAM_AW-1:0];
                if (fetch_hit)
                begin
                    s2_next.src = hcbd_pkg::BSRC_RAM;
                end
                else
                begin
                    s2_next.fixed = hcbd_pkg::FETCH_BLANK;
                end
            end
            hcbd_pkg::ACT_ROM_LOAD:
            begin
                rom_we = s1_v_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Video mode, attribute and sound latches
    always_comb
    begin
        mode_next  = mode_reg;
        attr_next  = attr_reg;
        sound_next = sound_reg;
        if (latch_we)
        begin
            mode_next  = hcbd_pkg::remap_mode(s1_data_reg);
            attr_next  = s1_data_reg[4];
            sound_next = s1_data_reg[7];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= '0;
            attr_reg  <= 1'b0;
            sound_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            attr_reg  <= attr_next;
            sound_reg <= sound_next;
        end
    end

    // ---------------- memories ----------------
    // The clearing pass owns the RAM port; no transaction is in flight meanwhile.
    assign ram_wdata = clear_reg ? '0 : s1_data_reg;

    hcbd_ram #(
        .WIDTH (hcbd_pkg::BYTE_W),
        .DEPTH (hcbd_pkg::RAM_DEPTH)
    ) u_main_ram (
        .clk   (clk),
        .we    (clear_reg || ram_we),
        .addr  (clear_reg ? clear_addr_reg : ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    hcbd_ram #(
        .WIDTH (hcbd_pkg::BYTE_W),
        .DEPTH (hcbd_pkg::ROM_DEPTH)
    ) u_basic_rom (
        .clk   (clk),
        .we    (rom_we),
        .addr  (s1_addr_reg[hcbd_pkg::ROM_AW-1:0]),
        .wdata (s1_data_reg),
        .rdata (rom_rdata)
    );

    // ---------------- stage 2: result assembly ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
    end

    logic [hcbd_pkg::BYTE_W-1:0] s2_byte;
    result_t                     s2_result;

    always_comb
    begin
        case (s2_reg.src)
            hcbd_pkg::BSRC_RAM: s2_byte = ram_rdata;
            hcbd_pkg::BSRC_ROM: s2_byte = rom_rdata;
            default:            s2_byte = s2_reg.fixed;
        endcase

        s2_result.read_data   = s2_reg.is_read ? s2_byte : '0;
        // byte in 7:0, copy of 7:6 in 9:8, attribute in 10
        s2_result.fetch_word  = s2_reg.is_fetch ? {s2_reg.attr, s2_byte[7:6], s2_byte} : '0;
        s2_result.screen_mode = s2_reg.mode;
        s2_result.sound_bit   = s2_reg.sound;
    end

    // ---------------- result queue ----------------
    result_t                      fifo_reg [hcbd_pkg::FIFO_DEPTH];
    logic [hcbd_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [hcbd_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic                         pop;

    assign pop = result.valid && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (s2_v_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + hcbd_pkg::FIFO_CW'(s2_v_reg) - hcbd_pkg::FIFO_CW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_v_reg)
        begin
            fifo_reg[wr_ptr_reg] <= s2_result;
        end
    end

    assign result.valid       = count_reg != '0;
    assign result.read_data   = fifo_reg[rd_ptr_reg].read_data;
    assign result.fetch_word  = fifo_reg[rd_ptr_reg].fetch_word;
    assign result.screen_mode = fifo_reg[rd_ptr_reg].screen_mode;
    assign result.sound_bit   = fifo_reg[rd_ptr_reg].sound_bit;

endmodule

/* rtl/core/hcbd_ram.sv */
// Generic single-port RAM with registered read (read-first).
module hcbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* bench/hcbd_bus_checker.sv */
// Bus decoder checker: watches both channels and the config port, predicts and compares results.
module hcbd_bus_checker
    import hcbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    hcbd_bus_if              bus,
    hcbd_result_if           result,
    input  logic             cfg_we,
    input  logic [KIB_W-1:0] cfg_wdata,
    output int               fail_count,
    output int               outstanding
);

    typedef struct packed {
        logic [BYTE_W-1:0]  read_data;
        logic [FETCH_W-1:0] fetch_word;
        logic [BYTE_W-1:0]  screen_mode;
        logic               sound_bit;
    } reply_t;

    // Shadow copy of the machine state.
    logic [BYTE_W-1:0] ram_img [RAM_DEPTH];
    logic [BYTE_W-1:0] rom_img [ROM_DEPTH];
    logic [KIB_W-1:0]  kib;
    logic [BYTE_W-1:0] mode;
    logic              attr;
    logic              sound;
    reply_t            due_replies [$];

    // Decode one transaction, update the shadow state, return the reply it causes.
    function automatic reply_t decode_access(input action_t act, input logic [ADDR_W-1:0] addr,
                                             input logic [BYTE_W-1:0] d,
                                             input logic [ROWS_W-1:0] rows);
        int                span;
        int                off;
        logic [BYTE_W-1:0] b;
        reply_t            r;
        span = int'(kib) * 1024;
        if (span > RAM_DEPTH)
            span = RAM_DEPTH;
        off = int'(addr) - QUAD_SPAN;
        r = '0;
        case (act)
            ACT_READ:
            begin
                r.read_data = d;
                case (quad_t'(addr[15:14]))
                    QUAD_RAM: if (off < span) r.read_data = ram_img[off];
                    QUAD_IO:
                    begin
                        if (span > QUAD_SPAN && off < span)
                            r.read_data = ram_img[off];
                        else
                            r.read_data = {2'b11, rows};
                    end
                    QUAD_ROM: r.read_data = rom_img[addr[ROM_AW-1:0]];
                    default: ;
                endcase
            end
            ACT_WRITE:
            begin
                if (addr[15:14] == QUAD_RAM)
                begin
                    if (off < span)
                        ram_img[off] = d;
                end
                else if (addr[15:14] == QUAD_IO)
                begin
                    if (span > QUAD_SPAN && off < span)
                    begin
                        ram_img[off] = d;
                    end
                    else
                    begin
                        mode  = {d[5], d[2], d[3], d[4], d[6], 3'b000};
                        attr  = d[4];
                        sound = d[7];
                    end
                end
            end
            ACT_FETCH:
            begin
                b = (int'(addr) < span) ? ram_img[addr[RAM_AW-1:0]] : 8'hff;
                r.fetch_word = {attr, b[7:6], b};
            end
            default: rom_img[addr[ROM_AW-1:0]] = d;
        endcase
        r.screen_mode = mode;
        r.sound_bit   = sound;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t want;
        reply_t got;
        int     errs;
        if (!rst_n)
        begin
            for (int i = 0; i < RAM_DEPTH; i++)
                ram_img[i] = '0;
            kib   = KIB_W'(KIB_RESET);
            mode  = '0;
            attr  = 1'b0;
            sound = 1'b0;
            due_replies.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_we)
                kib = cfg_wdata;
            if (bus.valid && bus.ready)
                due_replies.push_back(decode_access(bus.action, bus.address, bus.data,
                                                    bus.keyboard_rows));
            if (result.valid && result.ready)
            begin
                got = '{result.read_data, result.fetch_word, result.screen_mode,
                        result.sound_bit};
                if (due_replies.size() == 0)
                begin
                    $display("%0t: unexpected result rd=%h fw=%h mode=%h snd=%b", $time,
                             got.read_data, got.fetch_word, got.screen_mode, got.sound_bit);
                    errs++;
                end
                else
                begin
                    want = due_replies.pop_front();
                    if (got != want)
                    begin
                        $display({"%0t: mismatch expected rd=%h fw=%h mode=%h snd=%b,",
                                  " got rd=%h fw=%h mode=%h snd=%b"},
                                 $time, want.read_data, want.fetch_word, want.screen_mode,
                                 want.sound_bit, got.read_data, got.fetch_word,
                                 got.screen_mode, got.sound_bit);
                        errs++;
                    end
                end
            end
            fail_count  <= fail_count + errs;
            outstanding <= due_replies.size();
        end
    end

endmodule

/* bench/home_computer_bus_decoder_unit_tb.sv */
// Testbench top of the bus decoder: clock, reset, stimulus, result stalls and verdict.
module home_computer_bus_decoder_unit_tb;
    import hcbd_pkg::*;

    localparam int CLK_PERIOD = 12;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [KIB_W-1:0] cfg_wdata;
    int               fail_count;
    int               outstanding;

    // Last phase runs with no idling on either side.
    bit               quiet;
    // Installed size as last written; only shapes the stimulus.
    int               cur_kib;
    // ROM entries loaded so far: reads in the ROM quadrant only touch these.
    bit               rom_loaded [ROM_DEPTH];
    logic [ROM_AW-1:0] rom_offsets [$];
    // Recently written addresses, reused so that reads see earlier writes.
    logic [ADDR_W-1:0] recent_addrs [$];

    hcbd_bus_if    bus_ch ();
    hcbd_result_if res_ch ();

    home_computer_bus_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bus       (bus_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    hcbd_bus_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .bus         (bus_ch),
        .result      (res_ch),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Run limit. Slowest correct run: the RAM clear after reset, then roughly 430
    // transactions each paying a sender gap, a result stall and the pipeline
    // latency, plus drains between phases; the limit allows several times over.
    initial
    begin
        #(400_000 * CLK_PERIOD);
        $display("home_computer_bus_decoder_unit regression: fail");
        $finish;
    end

    // Result side: ready runs high for a random stretch, then drops for another random
    // stretch unless the quiet phase has started.
    initial
    begin
        int run;
        int stall;
        res_ch.ready = 1'b0;
        forever
        begin
            run = $urandom_range(1, 60);
            repeat (run) @(negedge clk) res_ch.ready <= 1'b1;
            if (!quiet)
            begin
                stall = $urandom_range(1, 17);
                repeat (stall) @(negedge clk) res_ch.ready <= 1'b0;
            end
        end
    end

    // Present one transaction at the falling edge and hold it until accepted.
    // valid stays high into the next call, so back-to-back transactions work.
    task automatic send_access(input action_t act, input logic [ADDR_W-1:0] addr,
                               input logic [BYTE_W-1:0] d, input logic [ROWS_W-1:0] rows);
        @(negedge clk);
        bus_ch.valid         <= 1'b1;
        bus_ch.action        <= act;
        bus_ch.address       <= addr;
        bus_ch.data          <= d;
        bus_ch.keyboard_rows <= rows;
        do @(posedge clk); while (!bus_ch.ready);
        if (act == ACT_ROM_LOAD && !rom_loaded[addr[ROM_AW-1:0]])
        begin
            rom_loaded[addr[ROM_AW-1:0]] = 1'b1;
            rom_offsets.push_back(addr[ROM_AW-1:0]);
        end
        if (act == ACT_WRITE)
        begin
            recent_addrs.push_back(addr);
            if (recent_addrs.size() > 16)
                void'(recent_addrs.pop_front());
        end
    endtask

    // Sender gap: valid drops and the bus idles for a length given by n.
    task automatic pause_bus(input int n);
        @(negedge clk);
        bus_ch.valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain_results();
        @(negedge clk);
        bus_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic set_ram_kib(input int kib);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= KIB_W'(kib);
        @(negedge clk);
        cfg_we  <= 1'b0;
        cur_kib = kib;
    endtask

    // One random transaction, biased toward the edges of installed RAM, the
    // keyboard/latch quadrant and readback of recent writes.
    task automatic random_access();
        int                span;
        int                lim;
        int                pick;
        action_t           act;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] d;
        logic [ROWS_W-1:0] rows;
        span = (cur_kib * 1024 > RAM_DEPTH) ? RAM_DEPTH : cur_kib * 1024;
        d    = BYTE_W'($urandom);
        rows = ROWS_W'($urandom);
        addr = ADDR_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35)
            act = ACT_READ;
        else if (pick < 65)
            act = ACT_WRITE;
        else if (pick < 88)
            act = ACT_FETCH;
        else
            act = ACT_ROM_LOAD;
        if (act == ACT_FETCH)
        begin
            // mostly around the end of installed RAM
            if ($urandom_range(0, 9) < 7)
                addr = ADDR_W'($urandom_range(0, span + 63));
        end
        else if (act != ACT_ROM_LOAD)
        begin
            lim = span + 63;
            if (lim > 16'h7fff)
                lim = 16'h7fff;
            case ($urandom_range(0, 9))
                0:          addr[15:14] = QUAD_FLOAT;
                1:          addr[15:14] = QUAD_ROM;
                2, 3, 4, 5: addr = ADDR_W'(QUAD_SPAN + $urandom_range(0, lim));
                6:
                begin
                    if (recent_addrs.size() != 0)
                        addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
                end
                7, 8:       addr[15:14] = QUAD_IO;
                default:    ;
            endcase
            // never read a ROM byte that was not loaded
            if (act == ACT_READ && addr[15:14] == QUAD_ROM &&
                !rom_loaded[addr[ROM_AW-1:0]])
            begin
                if (rom_offsets.size() != 0)
                    addr[ROM_AW-1:0] = rom_offsets[$urandom_range(0, rom_offsets.size() - 1)];
                else
                    addr[15] = 1'b0;
            end
        end
        send_access(act, addr, d, rows);
    endtask

    initial
    begin
        int kib_plan [8];
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        bus_ch.valid         = 1'b0;
        bus_ch.action        = ACT_READ;
        bus_ch.address       = '0;
        bus_ch.data          = '0;
        bus_ch.keyboard_rows = '0;
        quiet                = 1'b0;
        cur_kib              = KIB_RESET;
        // zero size, one KiB, range ends, quadrant 2 as RAM, saturation, boundary
        kib_plan = '{0, 1, 2, 20, 32, 63, 17, 16};
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset size (4K). The block is clearing RAM first;
        // the first transaction simply waits for ready.
        send_access(ACT_ROM_LOAD, 16'h0000, 8'ha5, 6'h00);
        send_access(ACT_ROM_LOAD, 16'hffff, 8'h5a, 6'h3f);   // high bits ignored
        send_access(ACT_READ,     16'hc000, 8'h00, 6'h00);
        send_access(ACT_READ,     16'hffff, 8'hff, 6'h3f);
        send_access(ACT_READ,     16'he000, 8'h11, 6'h00);   // ROM mirror
        send_access(ACT_WRITE,    16'hc000, 8'h00, 6'h00);   // ROM write dropped
        send_access(ACT_READ,     16'hc000, 8'h00, 6'h00);
        send_access(ACT_WRITE,    16'h4000, 8'hff, 6'h00);
        send_access(ACT_READ,     16'h4000, 8'h00, 6'h00);
        send_access(ACT_WRITE,    16'h4fff, 8'h81, 6'h00);   // last installed byte
        send_access(ACT_READ,     16'h4fff, 8'h00, 6'h00);
        send_access(ACT_WRITE,    16'h5000, 8'h77, 6'h00);   // past the end
        send_access(ACT_READ,     16'h5000, 8'h3c, 6'h00);
        send_access(ACT_READ,     16'h0000, 8'h00, 6'h00);   // floating bus
        send_access(ACT_READ,     16'h3fff, 8'hff, 6'h3f);
        send_access(ACT_WRITE,    16'h0000, 8'h12, 6'h00);   // unmapped write
        send_access(ACT_READ,     16'h8000, 8'h00, 6'h3f);   // keyboard rows
        send_access(ACT_READ,     16'hbfff, 8'hff, 6'h00);
        send_access(ACT_WRITE,    16'h8000, 8'hff, 6'h00);   // all latch bits set
        send_access(ACT_FETCH,    16'h0000, 8'h00, 6'h00);
        send_access(ACT_FETCH,    16'h0fff, 8'h00, 6'h00);
        send_access(ACT_FETCH,    16'h1000, 8'h00, 6'h00);   // fetch past the end
        send_access(ACT_FETCH,    16'hffff, 8'h00, 6'h00);
        send_access(ACT_WRITE,    16'hbfff, 8'h00, 6'h00);   // latches cleared
        send_access(ACT_FETCH,    16'h0000, 8'h00, 6'h00);

        repeat (40)
        begin
            if ($urandom_range(0, 7) == 0)
                pause_bus($urandom_range(1, 17));
            random_access();
        end

        // Random phases, each at its own installed size; the last one is quiet.
        kib_plan[7] = $urandom_range(2, 32);
        for (int ph = 0; ph < 8; ph++)
        begin
            drain_results();
            set_ram_kib(kib_plan[ph]);
            quiet = (ph == 7);
            for (int i = 0; i < 45; i++)
            begin
                // hold the sender until the pipeline is empty once
                if (ph == 2 && i == 22)
                    drain_results();
                if (!quiet && $urandom_range(0, 7) == 0)
                    pause_bus($urandom_range(1, 17));
                random_access();
            end
        end

        drain_results();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("home_computer_bus_decoder_unit regression: pass");
        else
            $display("home_computer_bus_decoder_unit regression: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/core/hcbd_pkg.sv
rtl/core/hcbd_if.sv
rtl/core/hcbd_ram.sv
rtl/core/home_computer_bus_decoder_unit.sv
bench/hcbd_bus_checker.sv
bench/home_computer_bus_decoder_unit_tb.sv
